>>> rtl/bmhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmhpq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int FILL_W       = 6;
  localparam int STATUS_W     = 2;
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

>>> rtl/binary_max_heap_priority_queue_unit.sv
// Max-priority queue of signed 32-bit values, held as a 1-based binary heap
// in a synchronous memory with two read ports and one write port.
//
// Slave side (s_*): one request per beat. s_tuser[0] is req_type (0 push,
// 1 pop), s_tdata carries the value to push. A new request is taken only
// when the engine has finished the previous one.
// Master side (m_*): one response per request. m_tuser holds status
// (0 ok, 1 push dropped because full, 2 pop on empty heap), m_tdata holds
// removed_value and fill_count (entries held after the request, mod 64).
//
// Each heap level is handled by a memory read state followed by a
// compare/write-back state. A pop first reads the root and the last entry
// (S_POP_RD, S_POP_LD); a full push or an empty pop goes straight to S_RESP.
// The next request is taken once S_RESP has returned to S_IDLE.
// The response waits in an output register, so a stalled receiver holds
// the engine in its final state only until the register frees.
// Reset clears the entry count, the engine state and the output valid;
// the heap memory itself is not cleared since only live slots are read.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_priority_queue_unit
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [DATA_W-1:0]      s_tdata,   // [31:0] value
  input  wire logic [0:0]             s_tuser,   // [0] req_type
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // [31:0] removed_value, [37:32] fill_count
  output logic [STATUS_W-1:0]         m_tuser    // [1:0] status
);

  localparam int AW = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0] heap_mem [1:CAPACITY];

  state_t state, state_next;

  logic [AW-1:0]            count;
  logic [AW-1:0]            pos;
  logic signed [DATA_W-1:0] cur_val;
  logic [DATA_W-1:0]        removed;
  status_t                  status;
  logic                     right_ok;

  logic [DATA_W-1:0] rd_a, rd_b;
  logic              rd_en;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic              in_beat;
  logic              out_free;
  logic [AW:0]       left_w, right_w;
  logic              at_leaf;
  logic              up_move;
  logic              pick_left, pick_right;
  logic [DATA_W-1:0] pick_val;
  logic [AW-1:0]     pick_addr;
  logic [AW+FILL_W-1:0] count_ext;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign left_w   = {pos, 1'b0};
  assign right_w  = left_w + 1'b1;
  assign at_leaf  = left_w > {1'b0, count};

  assign up_move  = cur_val > $signed(rd_a);

  // candidate starts at the parent; the right child must beat the winner so far
  always_comb begin
    pick_left  = $signed(rd_a) > cur_val;
    pick_val   = pick_left ? rd_a : cur_val;
    pick_right = right_ok && ($signed(rd_b) > $signed(pick_val));
    if (pick_right) begin
      pick_val = rd_b;
    end
    pick_addr = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  end

  assign count_ext = {{FILL_W{1'b0}}, count};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          if (req_t'(s_tuser[0]) == REQ_PUSH) begin
            state_next = (count >= AW'(CAPACITY)) ? S_RESP : S_UP_RD;
          end else begin
            state_next = (count == '0) ? S_RESP : S_POP_RD;
          end
        end
      end
      S_UP_RD:  state_next = (pos == AW'(1)) ? S_RESP : S_UP_CMP;
      S_UP_CMP: state_next = up_move ? S_UP_RD : S_RESP;
      S_POP_RD: state_next = S_POP_LD;
      S_POP_LD: state_next = S_DN_RD;
      S_DN_RD:  state_next = at_leaf ? S_RESP : S_DN_CMP;
      S_DN_CMP: state_next = (pick_left || pick_right) ? S_DN_RD : S_RESP;
      S_RESP:   state_next = out_free ? S_IDLE : S_RESP;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = AW'(1);
    rd_addr_b = AW'(1);
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur_val;
    case (state)
      S_UP_RD: begin
        if (pos == AW'(1)) begin
          mem_we = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = pos >> 1;
        end
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = up_move ? rd_a : cur_val;
      end
      S_POP_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = AW'(1);
        rd_addr_b = count;
      end
      S_DN_RD: begin
        if (at_leaf) begin
          // skip the write-back once the last entry has left
          mem_we = (count != '0);
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = left_w[AW-1:0];
          rd_addr_b = (right_w <= {1'b0, count}) ? right_w[AW-1:0] : left_w[AW-1:0];
        end
      end
      S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = pick_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a <= heap_mem[rd_addr_a];
      rd_b <= heap_mem[rd_addr_b];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            removed <= '0;
            cur_val <= $signed(s_tdata);
            if (req_t'(s_tuser[0]) == REQ_PUSH) begin
              if (count >= AW'(CAPACITY)) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
                count  <= count + 1'b1;
                pos    <= count + 1'b1;
              end
            end else if (count == '0) begin
              status <= ST_EMPTY;
            end else begin
              status <= ST_OK;
            end
          end
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos <= pos >> 1;
          end
        end
        S_DN_RD: begin
          right_ok <= right_w <= {1'b0, count};
        end
        S_POP_LD: begin
          // root leaves, last entry becomes the hole's value
          removed <= rd_a;
          cur_val <= $signed(rd_b);
          count   <= count - 1'b1;
          pos     <= AW'(1);
        end
        S_DN_CMP: begin
          if (pick_left || pick_right) begin
            pos <= pick_addr;
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tuser  <= status;
            m_tdata  <= {2'b00, count_ext[FILL_W-1:0], removed};
          end
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= AW'(CAPACITY))
    else $error("entry count above capacity");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr != '0 && mem_waddr <= count))
    else $error("heap write outside live slots");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tuser[0] == REQ_PUSH && count == AW'(CAPACITY)) |=> $stable(count))
    else $error("dropped push changed count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[DATA_W-1:0] == '0))
    else $error("empty pop returned nonzero value");

endmodule

`default_nettype wire
